FILE: rtl/kap_pkg.sv
`default_nettype none

package kap_pkg;

    localparam int unsigned START_W    = 14;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned IDX_W      = 2;

    // Division by ten through a reciprocal: q = (x * RECIP_10) >> RECIP_SHIFT.
    // The result is exact for every x below 2**START_W.
    localparam int unsigned RECIP_W     = 16;
    localparam int unsigned RECIP_10    = 52429;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned QUOT_W      = START_W + RECIP_W - RECIP_SHIFT;

    localparam logic [COUNT_W-1:0] MAX_ROUNDS = 3'd7;
    localparam logic [STEP_W-1:0]  STEP_NEVER = 4'hF;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // 6174 with the units digit in the lowest place.
    localparam digits_t TARGET_DIGITS = {4'd6, 4'd1, 4'd7, 4'd4};

    typedef struct packed {
        logic is_target;
        logic is_repdigit;
    } round_status_t;

endpackage

`default_nettype wire

FILE: rtl/kap_digit_split.sv
`default_nettype none

module kap_digit_split (
    input  wire logic [kap_pkg::START_W-1:0] rem_in,
    output logic      [kap_pkg::START_W-1:0] quot_out,
    output kap_pkg::digit_t                  digit_out
);

    logic [kap_pkg::START_W+kap_pkg::RECIP_W-1:0] prod;
    logic [kap_pkg::QUOT_W-1:0]                   quot;
    logic [kap_pkg::START_W-1:0]                  quot_ext;
    logic [kap_pkg::START_W-1:0]                  quot_x10;
    logic [kap_pkg::START_W-1:0]                  low_part;

    assign prod = {{kap_pkg::RECIP_W{1'b0}}, rem_in}
                * kap_pkg::RECIP_10[kap_pkg::START_W+kap_pkg::RECIP_W-1:0];
    assign quot     = prod[kap_pkg::START_W+kap_pkg::RECIP_W-1:kap_pkg::RECIP_SHIFT];
    assign quot_ext = {{(kap_pkg::START_W-kap_pkg::QUOT_W){1'b0}}, quot};

    // Times ten as two shifted copies.
    assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    assign low_part = rem_in - quot_x10;

    assign quot_out  = quot_ext;
    assign digit_out = low_part[kap_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/kap_round_unit.sv
`default_nettype none

module kap_round_unit (
    input  wire kap_pkg::digits_t  digits_in,
    output kap_pkg::digits_t       digits_out,
    output kap_pkg::round_status_t status
);

    kap_pkg::digit_t a0, a1, a2, a3;
    kap_pkg::digit_t b0, b1, b2, b3;
    kap_pkg::digit_t s0, s1, s2, s3;
    logic [3:0]      borrow;
    logic [4:0]      diff [kap_pkg::NUM_DIGITS];
    kap_pkg::digits_t desc_d;
    kap_pkg::digits_t asc_d;

    // Five compare-exchange steps sort four digits, s0 smallest.
    always_comb begin
        a0 = (digits_in[0] < digits_in[1]) ? digits_in[0] : digits_in[1];
        a1 = (digits_in[0] < digits_in[1]) ? digits_in[1] : digits_in[0];
        a2 = (digits_in[2] < digits_in[3]) ? digits_in[2] : digits_in[3];
        a3 = (digits_in[2] < digits_in[3]) ? digits_in[3] : digits_in[2];
        b0 = (a0 < a2) ? a0 : a2;
        b2 = (a0 < a2) ? a2 : a0;
        b1 = (a1 < a3) ? a1 : a3;
        b3 = (a1 < a3) ? a3 : a1;
        s0 = b0;
        s3 = b3;
        s1 = (b1 < b2) ? b1 : b2;
        s2 = (b1 < b2) ? b2 : b1;
    end

    assign desc_d = {s3, s2, s1, s0};
    assign asc_d  = {s0, s1, s2, s3};

    // Decimal subtraction, one digit at a time with a borrow ripple.
    always_comb begin
        borrow[0] = 1'b0;
        for (int i = 0; i < kap_pkg::NUM_DIGITS; i++) begin
            diff[i] = {1'b0, desc_d[i]} - {1'b0, asc_d[i]}
                    - {4'd0, (i == 0) ? 1'b0 : borrow[i[1:0]]};
            if (diff[i][4]) begin
                digits_out[i] = diff[i][3:0] + 4'd10;
            end else begin
                digits_out[i] = diff[i][3:0];
            end
            if (i < kap_pkg::NUM_DIGITS - 1) begin
                borrow[i[1:0] + 2'd1] = diff[i][4];
            end
        end
    end

    assign status.is_target   = (digits_in == kap_pkg::TARGET_DIGITS);
    assign status.is_repdigit = (digits_in[0] == digits_in[1])
                             && (digits_in[1] == digits_in[2])
                             && (digits_in[2] == digits_in[3]);

endmodule

`default_nettype wire

FILE: rtl/kaprekar_step_counter.sv
`default_nettype none
// Each word runs R sort-and-subtract rounds before its result is loaded into the output register,
// where R (0 to 7) is the number of rounds run; repdigits run none. The start number is split into
// decimal digits by a divide-by-ten unit, one digit per cycle, and then one sort-and-subtract
// round runs per cycle. A new word is accepted only once the previous one is done, so the block
// never takes a word while one is in work; a finished result also waits for a free output register.
// Reset (aresetn low at a clock edge) clears the sequencer and the output valid.

module kaprekar_step_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] start_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [3:0] step_count
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SPLIT = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    logic [1:0]                      state_reg,  state_next;
    logic [kap_pkg::START_W-1:0]     rem_reg,    rem_next;
    kap_pkg::digits_t                digits_reg, digits_next;
    logic [kap_pkg::IDX_W-1:0]       idx_reg,    idx_next;
    logic [kap_pkg::COUNT_W-1:0]     count_reg,  count_next;
    logic                            m_valid_reg, m_valid_next;
    logic [kap_pkg::STEP_W-1:0]      m_data_reg,  m_data_next;

    logic [kap_pkg::START_W-1:0]     split_quot;
    kap_pkg::digit_t                 split_digit;
    kap_pkg::digits_t                round_digits;
    kap_pkg::round_status_t          round_status;
    logic                            out_free;
    logic                            finish;

    kap_digit_split u_split (
        .rem_in    (rem_reg),
        .quot_out  (split_quot),
        .digit_out (split_digit)
    );

    kap_round_unit u_round (
        .digits_in  (digits_reg),
        .digits_out (round_digits),
        .status     (round_status)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign finish   = round_status.is_target || round_status.is_repdigit
                   || (count_reg == kap_pkg::MAX_ROUNDS);

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        digits_next  = digits_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next   = s_tdata[kap_pkg::START_W-1:0];
                    idx_next   = '0;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                // Only the low four digits are kept, which reduces the word modulo 10000.
                digits_next[idx_reg] = split_digit;
                rem_next             = split_quot;
                idx_next             = idx_reg + 2'd1;
                if (idx_reg == 2'(kap_pkg::NUM_DIGITS - 1)) begin
                    count_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (finish) begin
                    // The digits hold still here, so a stalled result is simply retried.
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = round_status.is_target
                                     ? {1'b0, count_reg} : kap_pkg::STEP_NEVER;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    digits_next = round_digits;
                    count_next  = count_reg + 3'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rem_reg    <= rem_next;
        digits_reg <= digits_next;
        idx_reg    <= idx_next;
        count_reg  <= count_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg};

endmodule

`default_nettype wire
